// ===== design/gsnd_pkg.sv =====
// Shared types, field layout and code constants for the gather/scatter ND engine.
`default_nettype none

package gsnd_pkg;

    localparam int CMD_W     = 2;
    localparam int BATCH_W   = 8;
    localparam int SEL_W     = 32;
    localparam int POS_W     = 6;
    localparam int SADDR_W   = 12;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int NUM_SEL   = 4;
    localparam int SEL_IDX_W = 2;
    localparam int DIM_W     = 13;
    localparam int DEPTH_W   = 3;
    localparam int SLICE_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 13;

    localparam int BATCH_LSB = 0;
    localparam int SEL_LSB   = BATCH_LSB + BATCH_W;
    localparam int POS_LSB   = SEL_LSB + NUM_SEL * SEL_W;
    localparam int SADDR_LSB = POS_LSB + POS_W;
    localparam int DIN_LSB   = SADDR_LSB + SADDR_W;
    localparam int IN_BITS   = DIN_LSB + WORD_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = WORD_W;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INDEX = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SEL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCATTER_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IN_USE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMS_PER_SLICE = 3'd7;

    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [SEL_W-1:0] sel_t;

endpackage

`default_nettype wire

// ===== design/gsnd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gsnd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/gather_scatter_nd_engine.sv =====
// Top level of the gather/scatter ND engine: sequencer, shared multiply-add unit and store.
// Load, an unused command or a bad direct address goes straight to the result; a read first
// does one store read. A new transaction is accepted only in idle, once the previous result
// has entered the output register; the single multiply-add unit is reused for each
// flattening step, the product, the batch term and the slice scaling, then one store access.
// Reset restores the configuration registers to their reset values; store contents are
// not initialized and must be loaded before use.
`default_nettype none

module gather_scatter_nd_engine #(
    parameter int STORE_DEPTH     = 4096,
    parameter int MAX_INDEX_DEPTH = 4,
    parameter int DATA_WIDTH      = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [gsnd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gsnd_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // batch, selector_0, selector_1, selector_2, selector_3, position, store_addr, data_in
    input  wire logic [gsnd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // command
    input  wire logic [gsnd_pkg::CMD_W-1:0]            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // data_out
    output logic [gsnd_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    // status
    output logic [gsnd_pkg::STATUS_W-1:0]              m_axis_tuser
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int AW1    = ADDR_W + 1;
    localparam int CW     = (AW1 > gsnd_pkg::DIM_W) ? AW1 : gsnd_pkg::DIM_W;
    localparam int PW     = AW1 + gsnd_pkg::DIM_W + 1;
    localparam int DEPTH_CAP = (MAX_INDEX_DEPTH < gsnd_pkg::NUM_SEL) ?
                               MAX_INDEX_DEPTH : gsnd_pkg::NUM_SEL;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFF,
        S_PROD,
        S_POS,
        S_SLICE,
        S_READ,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_LOAD,
        OP_READ,
        OP_INDEX
    } op_t;

    // configuration
    logic                                scatter_mode_reg;
    logic                                accumulate_reg;
    logic [gsnd_pkg::DEPTH_W-1:0]        depth_cfg_reg;
    gsnd_pkg::dim_t                      dim_size_reg [gsnd_pkg::NUM_SEL];
    logic [gsnd_pkg::SLICE_W-1:0]        slice_reg;

    // control
    state_t                              state_reg, state_next;
    logic                                out_valid_reg, out_valid_next;
    logic [gsnd_pkg::WORD_W-1:0]         out_data_reg, out_data_next;
    logic [gsnd_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;

    // datapath
    op_t                                 op_reg, op_next;
    logic [gsnd_pkg::STATUS_W-1:0]       stat_reg, stat_next;
    logic [gsnd_pkg::SEL_IDX_W-1:0]      h_reg, h_next;
    logic [gsnd_pkg::DEPTH_W-1:0]        depth_reg, depth_next;
    logic [AW1-1:0]                      offset_reg, offset_next;
    logic [AW1-1:0]                      prod_reg, prod_next;
    logic [AW1-1:0]                      addr_reg, addr_next;
    logic [gsnd_pkg::BATCH_W-1:0]        batch_reg, batch_next;
    gsnd_pkg::sel_t                      sel_reg [gsnd_pkg::NUM_SEL];
    gsnd_pkg::sel_t                      sel_next [gsnd_pkg::NUM_SEL];
    logic [gsnd_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [gsnd_pkg::WORD_W-1:0]         din_reg, din_next;

    // shared multiply-add unit
    logic [AW1-1:0]                      mul_a;
    gsnd_pkg::dim_t                      mul_b;
    logic [CW-1:0]                       add_c;
    logic [PW-1:0]                       mul_full;
    logic [AW1-1:0]                      mul_sat;

    gsnd_pkg::dim_t                      cur_size;
    gsnd_pkg::sel_t                      cur_sel;
    logic                                sel_bad;
    logic [gsnd_pkg::DEPTH_W-1:0]        depth_eff;
    logic                                in_fire;
    logic                                out_fire;
    logic [gsnd_pkg::SADDR_W-1:0]        in_saddr;

    logic                                ram_wr_en;
    logic                                ram_rd_en;
    logic [DATA_WIDTH-1:0]               ram_wr_data;
    logic [DATA_WIDTH-1:0]               ram_rd_data;
    logic [DATA_WIDTH-1:0]               din_word;
    logic [DATA_WIDTH-1:0]               sum_word;
    logic [DATA_WIDTH-1:0]               result_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scatter_mode_reg <= 1'b0;
            accumulate_reg   <= 1'b0;
            depth_cfg_reg    <= gsnd_pkg::DEPTH_W'(1);
            for (int i = 0; i < gsnd_pkg::NUM_SEL; i++)
            begin
                dim_size_reg[i] <= gsnd_pkg::DIM_W'(1);
            end
            slice_reg        <= gsnd_pkg::SLICE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                gsnd_pkg::CFG_SCATTER_MODE:    scatter_mode_reg <= cfg_data[0];
                gsnd_pkg::CFG_ACCUMULATE:      accumulate_reg   <= cfg_data[0];
                gsnd_pkg::CFG_DEPTH_IN_USE:    depth_cfg_reg    <= cfg_data[gsnd_pkg::DEPTH_W-1:0];
                gsnd_pkg::CFG_DIM_SIZE_0:      dim_size_reg[0]  <= cfg_data;
                gsnd_pkg::CFG_DIM_SIZE_1:      dim_size_reg[1]  <= cfg_data;
                gsnd_pkg::CFG_DIM_SIZE_2:      dim_size_reg[2]  <= cfg_data;
                gsnd_pkg::CFG_DIM_SIZE_3:      dim_size_reg[3]  <= cfg_data;
                gsnd_pkg::CFG_ELEMS_PER_SLICE: slice_reg        <= cfg_data[gsnd_pkg::SLICE_W-1:0];
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = (state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready);
    assign in_saddr      = s_axis_tdata[gsnd_pkg::SADDR_LSB +: gsnd_pkg::SADDR_W];

    assign depth_eff = (depth_cfg_reg > gsnd_pkg::DEPTH_W'(DEPTH_CAP)) ?
                       gsnd_pkg::DEPTH_W'(DEPTH_CAP) : depth_cfg_reg;

    assign cur_size = dim_size_reg[h_reg];
    assign cur_sel  = sel_reg[h_reg];
    assign sel_bad  = (cur_size == '0)
                   || (cur_sel[gsnd_pkg::SEL_W-1:gsnd_pkg::DIM_W] != '0)
                   || (cur_sel[gsnd_pkg::DIM_W-1:0] >= cur_size);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        add_c = '0;
        unique case (state_reg)
            S_OFF:
            begin
                mul_a = offset_reg;
                mul_b = cur_size;
                add_c = CW'(cur_sel[gsnd_pkg::DIM_W-1:0]);
            end
            S_PROD:
            begin
                mul_a = prod_reg;
                mul_b = cur_size;
            end
            S_POS:
            begin
                mul_a = prod_reg;
                mul_b = gsnd_pkg::DIM_W'(batch_reg);
                add_c = CW'(offset_reg);
            end
            S_SLICE:
            begin
                mul_a = addr_reg;
                mul_b = gsnd_pkg::DIM_W'(slice_reg);
                add_c = CW'(pos_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_full = PW'(mul_a) * PW'(mul_b) + PW'(add_c);
    assign mul_sat  = (mul_full > PW'(STORE_DEPTH)) ? AW1'(STORE_DEPTH) : AW1'(mul_full);

    assign din_word    = DATA_WIDTH'(din_reg);
    assign sum_word    = ram_rd_data + din_word;
    assign ram_rd_en   = (state_reg == S_READ);
    assign ram_wr_en   = out_fire
                      && ((op_reg == OP_LOAD) || ((op_reg == OP_INDEX) && scatter_mode_reg));
    assign ram_wr_data = (op_reg == OP_LOAD) ? din_word : result_word;

    always_comb
    begin
        if (scatter_mode_reg)
        begin
            result_word = accumulate_reg ? sum_word : din_word;
        end
        else
        begin
            result_word = accumulate_reg ? sum_word : ram_rd_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        op_next         = op_reg;
        stat_next       = stat_reg;
        h_next          = h_reg;
        depth_next      = depth_reg;
        offset_next     = offset_reg;
        prod_next       = prod_reg;
        addr_next       = addr_reg;
        batch_next      = batch_reg;
        sel_next        = sel_reg;
        pos_next        = pos_reg;
        din_next        = din_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    batch_next  = s_axis_tdata[gsnd_pkg::BATCH_LSB +: gsnd_pkg::BATCH_W];
                    for (int i = 0; i < gsnd_pkg::NUM_SEL; i++)
                    begin
                        sel_next[i] = s_axis_tdata[gsnd_pkg::SEL_LSB + i*gsnd_pkg::SEL_W
                                                   +: gsnd_pkg::SEL_W];
                    end
                    pos_next    = s_axis_tdata[gsnd_pkg::POS_LSB +: gsnd_pkg::POS_W];
                    din_next    = s_axis_tdata[gsnd_pkg::DIN_LSB +: gsnd_pkg::WORD_W];
                    addr_next   = AW1'(in_saddr);
                    h_next      = '0;
                    depth_next  = depth_eff;
                    offset_next = '0;
                    prod_next   = AW1'(1);
                    stat_next   = gsnd_pkg::STATUS_OK;
                    op_next     = OP_PASS;
                    state_next  = S_FINISH;
                    case (s_axis_tuser)
                        gsnd_pkg::CMD_LOAD, gsnd_pkg::CMD_READ:
                        begin
                            if (32'(in_saddr) >= 32'(STORE_DEPTH))
                            begin
                                stat_next = gsnd_pkg::STATUS_BAD_ADDR;
                            end
                            else if (s_axis_tuser == gsnd_pkg::CMD_LOAD)
                            begin
                                op_next = OP_LOAD;
                            end
                            else
                            begin
                                op_next    = OP_READ;
                                state_next = S_READ;
                            end
                        end
                        gsnd_pkg::CMD_INDEX:
                        begin
                            state_next = (depth_eff == '0) ? S_POS : S_OFF;
                        end
                        default:
                        begin
                            op_next = OP_PASS;
                        end
                    endcase
                end
            end
            S_OFF:
            begin
                if (sel_bad)
                begin
                    stat_next  = gsnd_pkg::STATUS_BAD_SEL;
                    state_next = S_FINISH;
                end
                else
                begin
                    offset_next = mul_sat;
                    state_next  = S_PROD;
                end
            end
            S_PROD:
            begin
                prod_next = mul_sat;
                h_next    = h_reg + gsnd_pkg::SEL_IDX_W'(1);
                if ((gsnd_pkg::DEPTH_W'(h_reg) + gsnd_pkg::DEPTH_W'(1)) == depth_reg)
                begin
                    state_next = S_POS;
                end
                else
                begin
                    state_next = S_OFF;
                end
            end
            S_POS:
            begin
                if (gsnd_pkg::SLICE_W'(pos_reg) >= slice_reg)
                begin
                    stat_next  = gsnd_pkg::STATUS_BAD_SEL;
                    state_next = S_FINISH;
                end
                else
                begin
                    addr_next  = mul_sat;
                    state_next = S_SLICE;
                end
            end
            S_SLICE:
            begin
                addr_next = mul_sat;
                if (mul_sat >= AW1'(STORE_DEPTH))
                begin
                    stat_next  = gsnd_pkg::STATUS_BAD_ADDR;
                    state_next = S_FINISH;
                end
                else
                begin
                    op_next    = OP_INDEX;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    unique case (op_reg)
                        OP_PASS:  out_data_next = din_reg;
                        OP_LOAD:  out_data_next = din_reg;
                        OP_READ:  out_data_next = gsnd_pkg::WORD_W'(ram_rd_data);
                        OP_INDEX: out_data_next = gsnd_pkg::WORD_W'(result_word);
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= gsnd_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        stat_reg   <= stat_next;
        h_reg      <= h_next;
        depth_reg  <= depth_next;
        offset_reg <= offset_next;
        prod_reg   <= prod_next;
        addr_reg   <= addr_next;
        batch_reg  <= batch_next;
        sel_reg    <= sel_next;
        pos_reg    <= pos_next;
        din_reg    <= din_next;
    end

    gsnd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg[ADDR_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input accepted while a transaction is in flight");

    a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |=> m_axis_tvalid)
        else $error("store written without a result transaction");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == gsnd_pkg::STATUS_OK)
                       || (m_axis_tuser == gsnd_pkg::STATUS_BAD_SEL)
                       || (m_axis_tuser == gsnd_pkg::STATUS_BAD_ADDR))
        else $error("undefined status code on result");

    a_access_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_rd_en || ram_wr_en) |-> (addr_reg < AW1'(STORE_DEPTH)))
        else $error("store access beyond its depth");

    a_dim_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OFF) |-> (gsnd_pkg::DEPTH_W'(h_reg) < depth_reg))
        else $error("selector step beyond dimensions in use");

endmodule

`default_nettype wire
